// ===== rtl/core/linear_interp_sample_rate_converter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the linear interpolation resampler
// Clocked property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_SAMPLE_RATE_CONVERTER_ASSERT_SVH
`define LINEAR_INTERP_SAMPLE_RATE_CONVERTER_ASSERT_SVH

// Checked only while out of reset
`define LISRC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("lisrc assertion failed");

// Checked on every edge, reset included
`define LISRC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("lisrc assertion failed");

`endif

// ===== rtl/core/lisrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lisrc_pkg
// Types and constants shared by the resampler front, back and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lisrc_pkg;

    // Field widths
    localparam int SAMPLE_BITS = 16;
    localparam int STEP_W      = 21;
    localparam int CFG_IDX_W   = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS    = CFG_IDX_W'(1);

    // At most 2^SPAN_LOG2 outputs per source span
    localparam int SPAN_LOG2 = 5;
    localparam int CNT_W     = SPAN_LOG2;

    // Command queue depth between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample sample_in;
        logic    end_of_clip;
    } t_in_item;

    typedef struct packed {
        t_sample sample_out;
        logic    last_out;
    } t_out_item;

    // What the back end has to do with a queued sample
    typedef enum logic [1:0] {
        KIND_BYPASS,
        KIND_PRIME,
        KIND_SPAN
    } t_kind;

    typedef struct packed {
        t_kind   kind;
        t_sample sample;
        logic    last;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

endpackage

// ===== rtl/core/lisrc_front.sv =====
// ----------------------------------------------------------------------------
// lisrc_front
// Accepts input samples, tags each with its processing kind and queues it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lisrc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lisrc_pkg::t_in_item i_in_data,
    input  logic                i_bypass,
    output lisrc_pkg::t_qhead   o_head,
    input  logic                i_pop
);
    import lisrc_pkg::*;

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              r_have_prev;
    logic              w_push;
    logic              w_pop;
    t_cmd              w_cmd;

    assign o_in_ready = (r_count != QCNT_W'(QDEPTH));
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_pop && (r_count != '0);

    // Classify: bypass, history only, or a span to interpolate
    always_comb begin
        w_cmd.sample = i_in_data.sample_in;
        w_cmd.last   = i_in_data.end_of_clip;
        if (i_bypass) begin
            w_cmd.kind = KIND_BYPASS;
        end else if (r_have_prev) begin
            w_cmd.kind = KIND_SPAN;
        end else begin
            w_cmd.kind = KIND_PRIME;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    // Pointers, fill count and history tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_have_prev <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
                if (i_in_data.end_of_clip) begin
                    r_have_prev <= 1'b0;
                end else if (!i_bypass) begin
                    r_have_prev <= 1'b1;
                end
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q[r_rd_ptr];

endmodule

// ===== rtl/core/lisrc_back.sv =====
// ----------------------------------------------------------------------------
// lisrc_back
// Output sequencer: walks the output phase over each source span; unless the
// output stalls it gives at most one interpolated, held or bypassed result per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lisrc_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lisrc_pkg::t_qhead             i_head,
    output logic                          o_pop,
    input  logic [lisrc_pkg::STEP_W-1:0]  i_rate_step,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lisrc_pkg::t_out_item          o_out_data
);
    import lisrc_pkg::*;

    localparam int POS_W = ((STEP_W > FRAC_BITS) ? STEP_W : FRAC_BITS) + 2;
    localparam logic [POS_W-1:0] ONE_POS  = POS_W'(1) << FRAC_BITS;
    localparam logic [POS_W-1:0] MIN_STEP = ONE_POS >> SPAN_LOG2;
    localparam logic [CNT_W-1:0] CNT_LAST = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INTERP,
        S_HOLD,
        S_ZERO
    } t_state;

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_sample          r_prev, n_prev;
    t_sample          r_cur, n_cur;
    logic             r_end, n_end;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out_data, n_out_data;

    logic                               w_slot_free;
    logic [POS_W-1:0]                   w_rate_ext;
    logic [POS_W-1:0]                   w_step;
    logic [POS_W-1:0]                   w_p2;
    logic                               w_wrap;
    logic [POS_W-1:0]                   w_adj;
    logic                               w_final;
    logic signed [SAMPLE_BITS:0]        w_diff;
    logic signed [FRAC_BITS:0]          w_frac;
    logic signed [SAMPLE_BITS+FRAC_BITS+1:0] w_prod;
    logic signed [SAMPLE_BITS+FRAC_BITS+1:0] w_shift;
    logic signed [SAMPLE_BITS:0]        w_sum;
    t_sample                            w_lerp;

    // Step with the lower clamp
    assign w_rate_ext = POS_W'(i_rate_step);
    assign w_step     = (w_rate_ext < MIN_STEP) ? MIN_STEP : w_rate_ext;

    // Phase lookahead
    assign w_p2    = r_pos + w_step;
    assign w_wrap  = (w_p2 >= ONE_POS);
    assign w_adj   = w_wrap ? (w_p2 - ONE_POS) : '0;
    assign w_final = w_wrap || (r_cnt == CNT_LAST);

    // prev + floor((cur - prev) * frac / 2^FRAC_BITS)
    assign w_diff  = {r_cur[SAMPLE_BITS-1], r_cur} - {r_prev[SAMPLE_BITS-1], r_prev};
    assign w_frac  = {1'b0, r_pos[FRAC_BITS-1:0]};
    assign w_prod  = w_diff * w_frac;
    assign w_shift = w_prod >>> FRAC_BITS;
    assign w_sum   = {r_prev[SAMPLE_BITS-1], r_prev} + w_shift[SAMPLE_BITS:0];
    assign w_lerp  = w_sum[SAMPLE_BITS-1:0];

    assign w_slot_free = !r_out_valid || i_out_ready;

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_end       = r_end;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    unique case (i_head.cmd.kind)
                        KIND_BYPASS: begin
                            if (w_slot_free) begin
                                o_pop                 = 1'b1;
                                n_out_valid           = 1'b1;
                                n_out_data.sample_out = i_head.cmd.sample;
                                n_out_data.last_out   = i_head.cmd.last;
                                if (i_head.cmd.last) begin
                                    n_pos  = '0;
                                    n_prev = '0;
                                end
                            end
                        end
                        KIND_PRIME: begin
                            o_pop = 1'b1;
                            n_cur = i_head.cmd.sample;
                            n_end = i_head.cmd.last;
                            n_cnt = '0;
                            if (i_head.cmd.last) begin
                                n_state = S_HOLD;
                            end else begin
                                n_prev = i_head.cmd.sample;
                            end
                        end
                        KIND_SPAN: begin
                            o_pop   = 1'b1;
                            n_cur   = i_head.cmd.sample;
                            n_end   = i_head.cmd.last;
                            n_cnt   = '0;
                            n_state = S_INTERP;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end

            S_INTERP: begin
                if (r_pos >= ONE_POS) begin
                    // span holds no output: move the phase on by one sample
                    n_pos = r_pos - ONE_POS;
                    if (!r_end) begin
                        n_prev  = r_cur;
                        n_state = S_IDLE;
                    end else if ((r_pos - ONE_POS) < ONE_POS) begin
                        n_cnt   = '0;
                        n_state = S_HOLD;
                    end else begin
                        n_state = S_ZERO;
                    end
                end else if (w_slot_free) begin
                    n_out_valid           = 1'b1;
                    n_out_data.sample_out = w_lerp;
                    n_out_data.last_out   = 1'b0;
                    if (!w_final) begin
                        n_pos = w_p2;
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_pos = w_adj;
                        if (!r_end) begin
                            n_prev  = r_cur;
                            n_state = S_IDLE;
                        end else if (w_adj < ONE_POS) begin
                            n_cnt   = '0;
                            n_state = S_HOLD;
                        end else begin
                            n_out_data.last_out = 1'b1;
                            n_pos   = '0;
                            n_prev  = '0;
                            n_state = S_IDLE;
                        end
                    end
                end
            end

            S_HOLD: begin
                // tail of the clip repeats the final sample
                if (w_slot_free) begin
                    n_out_valid           = 1'b1;
                    n_out_data.sample_out = r_cur;
                    n_out_data.last_out   = w_final;
                    if (w_final) begin
                        n_pos   = '0;
                        n_prev  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_pos = w_p2;
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end

            S_ZERO: begin
                // clip ended with no output: send an empty last marker
                if (w_slot_free) begin
                    n_out_valid           = 1'b1;
                    n_out_data.sample_out = '0;
                    n_out_data.last_out   = 1'b1;
                    n_pos   = '0;
                    n_prev  = '0;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
        end
        r_cur      <= n_cur;
        r_end      <= n_end;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/core/linear_interp_sample_rate_converter.sv =====
// Path: a bypass result goes from the queue head straight to the output register; the first
// interpolated or held result passes the queue pop and then the output register, and a clip
// end whose whole span is skipped passes the pop, the skip step and then the zero marker.
// Flow: at most one result per cycle while the output is taken, after each item's pop; a clip
// end at the minimum step gives up to 64 results; the two-entry command queue keeps input moving.
// Reset (synchronous, active low) empties queue and output, clears phase and history.
// ----------------------------------------------------------------------------
// linear_interp_sample_rate_converter
// Linear interpolation resampler: front classifier and queue, back sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_interp_sample_rate_converter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lisrc_pkg::t_in_item             i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lisrc_pkg::t_out_item            o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lisrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lisrc_pkg::STEP_W-1:0]    i_cfg_data
);
    import lisrc_pkg::*;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64'd1 << FRAC_BITS);

    logic [STEP_W-1:0] r_rate_step;
    logic              r_bypass;
    t_qhead            w_head;
    logic              w_pop;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_step <= STEP_RESET;
            r_bypass    <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RATE_STEP: r_rate_step <= i_cfg_data;
                CFG_BYPASS:    r_bypass    <= i_cfg_data[0];
                default:       r_bypass    <= r_bypass;
            endcase
        end
    end

    lisrc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_bypass   (r_bypass),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    lisrc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_rate_step (r_rate_step),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/core/lisrc_checker.sv =====
// ----------------------------------------------------------------------------
// lisrc_checker
// Port-level checks on the resampler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_interp_sample_rate_converter_assert.svh"

module lisrc_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input lisrc_pkg::t_out_item  o_out_data,
    input logic                  o_cfg_ready
);
    import lisrc_pkg::*;

    // A stalled result stays put until its transfer
    `LISRC_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))

    // Reset empties the output register
    `LISRC_ASSERT_ALWAYS(a_rst_out_empty, !i_rst_n |=> !o_out_valid)

    // Reset empties the command queue, so input opens at once
    `LISRC_ASSERT_ALWAYS(a_rst_in_open, !i_rst_n |=> o_in_ready)

    // Configuration writes are never refused
    `LISRC_ASSERT(a_cfg_open, o_cfg_ready)

endmodule

bind linear_interp_sample_rate_converter lisrc_checker u_lisrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .o_cfg_ready (o_cfg_ready)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: linear interpolation resampler testbench
// Drives sample streams through the resampler under a series of rate and
// bypass settings, with random gaps on both handshakes. An internal
// interpolation predictor works out the expected outputs for every accepted
// sample, and the output monitor compares each output transfer against them
// in order.
// ----------------------------------------------------------------------------

module tb_top;
    import lisrc_pkg::*;

    localparam int          FRAC_BITS     = 16;
    localparam int unsigned ONE_POS       = 1 << FRAC_BITS;
    localparam int unsigned MAX_SPAN      = 1 << SPAN_LOG2;
    localparam int unsigned MIN_STEP      = ONE_POS >> SPAN_LOG2;
    localparam int unsigned STEP_HIGH     = 24 * ONE_POS;
    localparam int unsigned STEP_ALL_ONES = (1 << STEP_W) - 1;
    localparam int          RANDOM_ITEMS  = 240;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          DRAIN_CYCLES  = 100000;
    localparam int          MAX_WAIT      = 12;
    localparam int          REPORT_LIMIT  = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG   = CFG_IDX_W'(CFG_BYPASS + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX  = '1;
    localparam t_sample              SAMPLE_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample              SAMPLE_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    t_in_item              in_data = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [STEP_W-1:0]     cfg_data = '0;

    // Stimulus and expected outputs
    t_in_item    sample_q[$];
    t_out_item   expected_out[$];
    int unsigned items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned results_seen = 0;
    int unsigned settings_used = 0;
    int unsigned errors = 0;
    logic        no_idle = 1'b0;

    logic [3:0]  in_gap = '0;
    logic [3:0]  out_stall = '0;

    // Predictor copy of registers and interpolation state
    logic [STEP_W-1:0] rate_step_q = STEP_W'(ONE_POS);
    logic              bypass_q = 1'b1;
    t_sample           prev_q = '0;
    logic              have_prev_q = 1'b0;
    int unsigned       next_pos_q = 0;

    linear_interp_sample_rate_converter #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [3:0] draw_wait();
        return no_idle ? 4'd0 : 4'($urandom_range(0, MAX_WAIT));
    endfunction

    // prev + floor((cur - prev) * frac / 2^FRAC_BITS); arithmetic shift floors
    function automatic t_sample interp(input t_sample a, input t_sample b,
                                       input int unsigned frac);
        longint prod;
        prod = (longint'(b) - longint'(a)) * longint'(frac);
        return t_sample'(longint'(a) + (prod >>> FRAC_BITS));
    endfunction

    // Append one output to the expected list
    function automatic void queue_result(input t_out_item r);
        expected_out.insert(expected_out.size(), r);
    endfunction

    // Work out every output caused by one accepted sample.
    // The newest output is held back so the clip-end flag can be set on it.
    function automatic void predict_outputs(input t_in_item item);
        t_out_item   held;
        logic        have_held;
        int unsigned step;
        int unsigned k;
        have_held = 1'b0;
        held = '0;
        step = (rate_step_q < MIN_STEP) ? MIN_STEP : int'(rate_step_q);
        if (bypass_q) begin
            held.sample_out = item.sample_in;
            held.last_out = item.end_of_clip;
            queue_result(held);
            if (item.end_of_clip) begin
                prev_q = '0;
                have_prev_q = 1'b0;
                next_pos_q = 0;
            end
            return;
        end
        // interpolated outputs between previous and current sample
        if (have_prev_q) begin
            k = 0;
            while (next_pos_q < ONE_POS && k < MAX_SPAN) begin
                if (have_held) queue_result(held);
                held.sample_out = interp(prev_q, item.sample_in, next_pos_q);
                held.last_out = 1'b0;
                have_held = 1'b1;
                k++;
                next_pos_q += step;
            end
            next_pos_q = (next_pos_q >= ONE_POS) ? next_pos_q - ONE_POS : 0;
        end
        if (item.end_of_clip) begin
            // tail of the clip holds the last sample
            k = 0;
            while (next_pos_q < ONE_POS && k < MAX_SPAN) begin
                if (have_held) queue_result(held);
                held.sample_out = item.sample_in;
                held.last_out = 1'b0;
                have_held = 1'b1;
                k++;
                next_pos_q += step;
            end
            // a clip end with no outputs still sends a zero flagged last
            if (!have_held) held.sample_out = '0;
            held.last_out = 1'b1;
            queue_result(held);
            prev_q = '0;
            have_prev_q = 1'b0;
            next_pos_q = 0;
        end else begin
            if (have_held) queue_result(held);
            prev_q = item.sample_in;
            have_prev_q = 1'b1;
        end
    endfunction

    // Input driver: one sample per transfer, random gap after each
    always @(posedge clk) begin : drive_samples
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap <= '0;
        end else begin
            if (in_valid && in_ready) begin
                predict_outputs(in_data);
                items_taken++;
            end
            if (in_valid && !in_ready) begin
                // hold the item until it is taken
            end else if (in_gap != 0) begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1'b1;
            end else if (sample_q.size() != 0) begin
                in_data <= sample_q.pop_front();
                in_valid <= 1'b1;
                in_gap <= draw_wait();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: random stall after each transfer, in-order compare
    always @(posedge clk) begin : watch_outputs
        t_out_item  want;
        logic [3:0] stall_next;
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_stall <= '0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_out.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("unexpected output: sample %0d last %0b",
                                 out_data.sample_out, out_data.last_out);
                end else begin
                    want = expected_out.pop_front();
                    if (out_data.sample_out !== want.sample_out ||
                        out_data.last_out !== want.last_out) begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("output %0d: expected sample %0d last %0b,",
                                     results_seen, want.sample_out, want.last_out,
                                     " got sample %0d last %0b",
                                     out_data.sample_out, out_data.last_out);
                    end
                end
                stall_next = draw_wait();
            end else begin
                stall_next = (out_stall != 0) ? out_stall - 1'b1 : 4'd0;
            end
            out_stall <= stall_next;
            out_ready <= (stall_next == 0);
        end
    end

    task automatic add_item(input t_sample s, input logic eoc);
        t_in_item it;
        it.sample_in = s;
        it.end_of_clip = eoc;
        sample_q.insert(sample_q.size(), it);
        items_queued++;
    endtask

    // One register write transfer; predictor copy updated on acceptance
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_RATE_STEP) rate_step_q = val;
        else if (idx == CFG_BYPASS) bypass_q = val[0];
    endtask

    // Quiet point: all samples taken, all outputs seen, sequencer settled
    task automatic wait_idle();
        int unsigned spins;
        spins = 0;
        while ((items_taken != items_queued || expected_out.size() != 0) &&
               spins < DRAIN_CYCLES) begin
            @(posedge clk);
            spins++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // New rate and bypass setting; upper bypass data bits carry noise
    task automatic set_mode(input int unsigned step, input logic bypass_on);
        logic [STEP_W-1:0] byp_word;
        wait_idle();
        byp_word = STEP_W'({$urandom, bypass_on});
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_RATE_STEP, STEP_W'(step));
            write_reg(CFG_BYPASS, byp_word);
        end else begin
            write_reg(CFG_BYPASS, byp_word);
            write_reg(CFG_RATE_STEP, STEP_W'(step));
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_NO_REG, CFG_TOP_IDX)), STEP_W'($urandom));
        settings_used++;
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            1: return t_sample'(int'($urandom_range(0, 512)) - 256);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_step();
        case ($urandom_range(0, 7))
            0: return MIN_STEP;
            1: return STEP_HIGH;
            2: return $urandom_range(0, MIN_STEP - 1);
            3: return STEP_ALL_ONES;
            4: return ONE_POS - 2 + $urandom_range(0, 4);
            5: return $urandom_range(MIN_STEP, ONE_POS);
            default: return $urandom_range(MIN_STEP, STEP_HIGH);
        endcase
    endfunction

    initial begin : stimulus
        int random_items;
        int phase_left;
        int kind;
        int len;
        random_items = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset setting: bypass, extremes pass straight through
        add_item(SAMPLE_MAX, 1'b0);
        add_item(SAMPLE_MIN, 1'b1);
        add_item('0, 1'b0);
        add_item(t_sample'(-1), 1'b1);

        // Minimum step: full 32-output spans, then a 64-output clip end
        set_mode(MIN_STEP, 1'b0);
        add_item(SAMPLE_MIN, 1'b0);
        add_item(SAMPLE_MAX, 1'b0);
        add_item(SAMPLE_MIN, 1'b1);
        add_item(t_sample'(12345), 1'b1);   // one-sample clip: tail only

        // Step below range is clamped; writes to unused indexes are dropped
        set_mode(0, 1'b0);
        write_reg(CFG_NO_REG, '1);
        write_reg(CFG_TOP_IDX, '0);
        add_item(t_sample'(100), 1'b0);
        add_item(t_sample'(-100), 1'b1);

        // Step of 24 samples: clip end with nothing due gives a zero flagged last
        set_mode(STEP_HIGH, 1'b0);
        add_item(t_sample'(1000), 1'b0);
        add_item(t_sample'(2000), 1'b0);
        add_item(t_sample'(3000), 1'b1);

        set_mode(STEP_ALL_ONES, 1'b0);
        add_item(t_sample'(5), 1'b0);
        add_item(t_sample'(6), 1'b1);

        // Unity and 1.5 steps, negative slopes to check floor rounding
        set_mode(ONE_POS, 1'b0);
        add_item(SAMPLE_MIN, 1'b0);
        add_item(SAMPLE_MAX, 1'b0);
        add_item(t_sample'(7), 1'b1);
        set_mode(ONE_POS + ONE_POS / 2, 1'b0);
        add_item(t_sample'(300), 1'b0);
        add_item(t_sample'(-301), 1'b0);
        add_item(SAMPLE_MIN, 1'b1);

        // Random settings with mostly complete clips, some noise and broken clips
        while (random_items < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            set_mode(pick_step(), $urandom_range(0, 4) == 0);
            phase_left = $urandom_range(15, 40);
            while (phase_left > 0) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) len = 1;
                else if ($urandom_range(0, 7) == 0) len = $urandom_range(9, 30);
                else len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    if (kind == 0)
                        add_item(rand_sample(), 1'($urandom_range(0, 1)));
                    else
                        add_item(rand_sample(), kind != 1 && i == len - 1);
                end
                random_items += len;
                phase_left -= len;
            end
        end

        wait_idle();
        if (items_taken != items_queued || expected_out.size() != 0) begin
            errors++;
            $display("%0d samples not taken, %0d outputs never arrived",
                     items_queued - items_taken, expected_out.size());
        end
        $display("Run covered %0d input samples over %0d rate/bypass settings,",
                 items_taken, settings_used);
        $display("with %0d output transfers checked against the predictor.",
                 results_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run
    initial begin : watchdog
        #10_000_000;
        $display("run stopped by time limit");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lisrc_pkg.sv
rtl/core/lisrc_front.sv
rtl/core/lisrc_back.sv
rtl/core/linear_interp_sample_rate_converter.sv
rtl/core/lisrc_checker.sv
dv/tb_top.sv
